FILE: design/gatc_pkg.sv
package gatc_pkg;

    // Fixed field widths
    localparam int TIME_W   = 32;
    localparam int BITS_W   = 4;
    localparam int AXIS_W   = 16;
    localparam int NUM_AXES = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [AXIS_W-1:0] AXIS_SAT = {AXIS_W{1'b1}};

    // Input item actions
    localparam logic ACT_TRIGGER = 1'b0;
    localparam logic ACT_SAMPLE  = 1'b1;

    // Register reset values
    localparam logic [BITS_W-1:0] RST_AXIS_MASK      = 4'd15;
    localparam logic [TIME_W-1:0] RST_POLL_GAP_LIMIT = 32'd100;
    localparam logic [TIME_W-1:0] RST_CAPTURE_TIMEOUT = 32'd3000;
    localparam logic [TIME_W-1:0] RST_TICKS_PER_MS   = 32'd1000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_MASK       = 2'd0,
        REG_POLL_GAP_LIMIT  = 2'd1,
        REG_CAPTURE_TIMEOUT = 2'd2,
        REG_TICKS_PER_MS    = 2'd3
    } cfg_reg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_LOAD,
        ST_DIV,
        ST_APPLY,
        ST_EMIT
    } gatc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic apply;
        logic emit;
    } gatc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic end_capture;
        logic has_changes;
        logic div_last;
        logic idx_zero;
        logic out_free;
    } gatc_sts_t;

endpackage

FILE: design/gameport_axis_timing_capture_core.sv
// Game port RC axis timing capture. A trigger transaction (action 0) starts a
// capture; sample transactions (action 1) are taken one per cycle while the
// block accepts input, and bit changes are logged with their timestamps into a
// store of MAX_CHANGES entries. When a capture ends the block stops taking
// input while one shared restoring divider scales each logged change to
// ((t - start) << SCALE_SHIFT) / ticks_per_ms, one quotient bit per cycle;
// each change is loaded, divided and applied, then the result register is loaded.
// The result then waits in that register while new items are accepted; a
// second capture end waits for it to be taken. Configuration is written
// through the cfg port, which is always ready.
module gameport_axis_timing_capture_core #(
    parameter int MAX_CHANGES = 4,
    parameter int SCALE_SHIFT = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gatc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gatc_pkg::TIME_W-1:0]      cfg_data,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_action,
    input  logic [gatc_pkg::BITS_W-1:0]      s_port_bits,
    input  logic [gatc_pkg::TIME_W-1:0]      s_timestamp,
    // results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [gatc_pkg::AXIS_W-1:0]      m_axis_0,
    output logic [gatc_pkg::AXIS_W-1:0]      m_axis_1,
    output logic [gatc_pkg::AXIS_W-1:0]      m_axis_2,
    output logic [gatc_pkg::AXIS_W-1:0]      m_axis_3,
    output logic                             m_capture_ok
);

    gatc_pkg::gatc_cmd_t cmd;
    gatc_pkg::gatc_sts_t sts;

    assign cfg_ready = 1'b1;

    gatc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gatc_datapath #(
        .MAX_CHANGES (MAX_CHANGES),
        .SCALE_SHIFT (SCALE_SHIFT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_action     (s_action),
        .s_port_bits  (s_port_bits),
        .s_timestamp  (s_timestamp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_axis_0     (m_axis_0),
        .m_axis_1     (m_axis_1),
        .m_axis_2     (m_axis_2),
        .m_axis_3     (m_axis_3),
        .m_capture_ok (m_capture_ok),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

FILE: design/gatc_ctrl.sv
module gatc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gatc_pkg::gatc_sts_t sts,
    output gatc_pkg::gatc_cmd_t cmd
);

    gatc_pkg::gatc_state_t state_reg, state_next;

    // Hold the controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gatc_pkg::ST_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence item intake, per-change scaling and result hand-off
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            gatc_pkg::ST_ACCEPT: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && sts.end_capture) begin
                    state_next = sts.has_changes ? gatc_pkg::ST_LOAD : gatc_pkg::ST_EMIT;
                end
            end
            gatc_pkg::ST_LOAD: begin
                cmd.div_load = 1'b1;
                state_next   = gatc_pkg::ST_DIV;
            end
            gatc_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = gatc_pkg::ST_APPLY;
                end
            end
            gatc_pkg::ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = sts.idx_zero ? gatc_pkg::ST_EMIT : gatc_pkg::ST_LOAD;
            end
            gatc_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = gatc_pkg::ST_ACCEPT;
                end
            end
            default: begin
                state_next = gatc_pkg::ST_ACCEPT;
            end
        endcase
    end

endmodule

FILE: design/gatc_datapath.sv
module gatc_datapath #(
    parameter int MAX_CHANGES = 4,
    parameter int SCALE_SHIFT = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [gatc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gatc_pkg::TIME_W-1:0]          cfg_data,
    // input item
    input  logic                                 s_action,
    input  logic [gatc_pkg::BITS_W-1:0]          s_port_bits,
    input  logic [gatc_pkg::TIME_W-1:0]          s_timestamp,
    // result
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [gatc_pkg::AXIS_W-1:0]          m_axis_0,
    output logic [gatc_pkg::AXIS_W-1:0]          m_axis_1,
    output logic [gatc_pkg::AXIS_W-1:0]          m_axis_2,
    output logic [gatc_pkg::AXIS_W-1:0]          m_axis_3,
    output logic                                 m_capture_ok,
    // controller link
    input  gatc_pkg::gatc_cmd_t                  cmd,
    output gatc_pkg::gatc_sts_t                  sts
);

    localparam int TW     = gatc_pkg::TIME_W;
    localparam int BW     = gatc_pkg::BITS_W;
    localparam int AW     = gatc_pkg::AXIS_W;
    localparam int NA     = gatc_pkg::NUM_AXES;
    localparam int CNT_W  = $clog2(MAX_CHANGES + 1);
    localparam int IDX_W  = (MAX_CHANGES > 1) ? $clog2(MAX_CHANGES) : 1;
    localparam int DIV_W  = TW + SCALE_SHIFT;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    // configuration registers
    logic [BW-1:0] axis_mask_reg;
    logic [TW-1:0] poll_gap_limit_reg;
    logic [TW-1:0] capture_timeout_reg;
    logic [TW-1:0] ticks_per_ms_reg;

    // capture state
    logic [TW-1:0]    start_time_reg;
    logic [TW-1:0]    prev_time_reg;
    logic [BW-1:0]    prev_bits_reg;
    logic [CNT_W-1:0] change_count_reg;
    logic             capturing_reg;
    logic [BW-1:0]    change_bits_reg [MAX_CHANGES];
    logic [TW-1:0]    change_time_reg [MAX_CHANGES];
    logic [AW-1:0]    axis_value_reg  [NA];

    // end-of-capture scan
    logic [IDX_W-1:0] idx_reg;
    logic [BW-1:0]    seen_reg;
    logic             cur_zero_reg;

    // divider
    logic [TW-1:0]     rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DCNT_W-1:0] div_cnt_reg;

    // output register
    logic          m_valid_reg;
    logic [AW-1:0] m_axis_reg [NA];
    logic          m_ok_reg;

    // sample evaluation
    logic [BW-1:0]    cur_bits;
    logic [BW-1:0]    diff_bits;
    logic [TW-1:0]    poll_gap;
    logic [TW-1:0]    elapsed;
    logic             record;
    logic [CNT_W-1:0] count_new;
    logic             sample_done;

    // divider step
    logic [TW:0]   rem_shift;
    logic [TW:0]   rem_sub;
    logic          quo_bit;
    logic [TW-1:0] delta;
    logic [AW-1:0] scaled;

    // Evaluate the sample on the port
    always_comb begin
        cur_bits  = s_port_bits & axis_mask_reg;
        diff_bits = prev_bits_reg ^ cur_bits;
        poll_gap  = s_timestamp - prev_time_reg;
        elapsed   = s_timestamp - start_time_reg;
        record    = (diff_bits != '0) && (poll_gap < poll_gap_limit_reg)
                    && (change_count_reg < CNT_W'(MAX_CHANGES));
        count_new = record ? change_count_reg + CNT_W'(1) : change_count_reg;
        sample_done = !((cur_bits != '0) && (count_new < CNT_W'(MAX_CHANGES))
                        && (elapsed < capture_timeout_reg));
    end

    // Restoring divide step, one quotient bit per cycle
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        rem_sub   = rem_shift - {1'b0, ticks_per_ms_reg};
        quo_bit   = (rem_shift >= {1'b0, ticks_per_ms_reg});
        delta     = change_time_reg[idx_reg] - start_time_reg;
        scaled    = (quo_reg[DIV_W-1:AW] != '0) ? gatc_pkg::AXIS_SAT : quo_reg[AW-1:0];
    end

    // Report status to the controller
    always_comb begin
        sts.end_capture = capturing_reg && (s_action == gatc_pkg::ACT_SAMPLE) && sample_done;
        sts.has_changes = (count_new != '0);
        sts.div_last    = (div_cnt_reg == DCNT_W'(1));
        sts.idx_zero    = (idx_reg == '0);
        sts.out_free    = !m_valid_reg || m_ready;
    end

    // Take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_mask_reg       <= gatc_pkg::RST_AXIS_MASK;
            poll_gap_limit_reg  <= gatc_pkg::RST_POLL_GAP_LIMIT;
            capture_timeout_reg <= gatc_pkg::RST_CAPTURE_TIMEOUT;
            ticks_per_ms_reg    <= gatc_pkg::RST_TICKS_PER_MS;
        end else if (cfg_we) begin
            unique case (gatc_pkg::cfg_reg_t'(cfg_index))
                gatc_pkg::REG_AXIS_MASK:       axis_mask_reg       <= cfg_data[BW-1:0];
                gatc_pkg::REG_POLL_GAP_LIMIT:  poll_gap_limit_reg  <= cfg_data;
                gatc_pkg::REG_CAPTURE_TIMEOUT: capture_timeout_reg <= cfg_data;
                gatc_pkg::REG_TICKS_PER_MS:    ticks_per_ms_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the capture on each accepted trigger, and on each accepted sample while capturing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_time_reg   <= '0;
            prev_time_reg    <= '0;
            prev_bits_reg    <= '0;
            change_count_reg <= '0;
            capturing_reg    <= 1'b0;
        end else if (cmd.accept) begin
            if (s_action == gatc_pkg::ACT_TRIGGER) begin
                start_time_reg   <= s_timestamp;
                prev_time_reg    <= s_timestamp;
                prev_bits_reg    <= axis_mask_reg;
                change_count_reg <= '0;
                capturing_reg    <= 1'b1;
            end else if (capturing_reg) begin
                prev_time_reg    <= s_timestamp;
                prev_bits_reg    <= cur_bits;
                change_count_reg <= count_new;
                if (sample_done) begin
                    capturing_reg <= 1'b0;
                end
            end
        end
    end

    // Record a change in the change store
    always_ff @(posedge aclk) begin
        if (cmd.accept && (s_action == gatc_pkg::ACT_SAMPLE) && capturing_reg && record) begin
            change_bits_reg[change_count_reg[IDX_W-1:0]] <= diff_bits;
            change_time_reg[change_count_reg[IDX_W-1:0]] <= s_timestamp;
        end
    end

    // Walk the recorded changes from latest to earliest
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            seen_reg     <= '0;
            cur_zero_reg <= 1'b0;
        end else if (cmd.accept && sts.end_capture) begin
            idx_reg      <= IDX_W'(count_new - CNT_W'(1));
            seen_reg     <= '0;
            cur_zero_reg <= (cur_bits == '0);
        end else if (cmd.apply) begin
            seen_reg <= seen_reg | change_bits_reg[idx_reg];
            if (idx_reg != '0) begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
    end

    // Load and iterate the divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_load) begin
            div_cnt_reg <= DCNT_W'(DIV_W);
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg <= '0;
            quo_reg <= {delta, {SCALE_SHIFT{1'b0}}};
        end else if (cmd.div_step) begin
            rem_reg <= quo_bit ? rem_sub[TW-1:0] : rem_shift[TW-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], quo_bit};
        end
    end

    // Write the scaled time into each axis of the change
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NA; j++) begin
                axis_value_reg[j] <= '0;
            end
        end else if (cmd.apply) begin
            for (int j = 0; j < NA; j++) begin
                if (change_bits_reg[idx_reg][j]) begin
                    axis_value_reg[j] <= scaled;
                end
            end
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            for (int j = 0; j < NA; j++) begin
                m_axis_reg[j] <= axis_value_reg[j];
            end
            m_ok_reg <= cur_zero_reg && (seen_reg == axis_mask_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_axis_0     = m_axis_reg[0];
    assign m_axis_1     = m_axis_reg[1];
    assign m_axis_2     = m_axis_reg[2];
    assign m_axis_3     = m_axis_reg[3];
    assign m_capture_ok = m_ok_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        change_count_reg <= CNT_W'(MAX_CHANGES))
        else $error("change count exceeds the store depth");

    a_step_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (div_cnt_reg != '0))
        else $error("divider stepped without a loaded operand");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("result not presented after emit");

    a_no_emit_over: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.emit)
        else $error("result overwritten before it was taken");
`endif

endmodule

FILE: tb/testbench.sv
module testbench;
    import gatc_pkg::*;

    localparam int MAX_CHANGES    = 4;
    localparam int SCALE_SHIFT    = 12;
    // one divide per logged change plus the result load, with margin
    localparam int SETTLE_CYCLES  = 250;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int HOLD_CYCLES    = 800;
    localparam int RANDOM_ITEMS   = 1450;
    localparam int PHASE_CAPTURES = 25;

    typedef struct packed {
        logic [NUM_AXES-1:0][AXIS_W-1:0] axes;
        logic                            ok;
    } capture_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TIME_W-1:0]    cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_action;
    logic [BITS_W-1:0]    s_port_bits;
    logic [TIME_W-1:0]    s_timestamp;
    logic                 m_valid;
    logic                 m_ready;
    logic [AXIS_W-1:0]    m_axis_0;
    logic [AXIS_W-1:0]    m_axis_1;
    logic [AXIS_W-1:0]    m_axis_2;
    logic [AXIS_W-1:0]    m_axis_3;
    logic                 m_capture_ok;

    gameport_axis_timing_capture_core #(
        .MAX_CHANGES (MAX_CHANGES),
        .SCALE_SHIFT (SCALE_SHIFT)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_port_bits  (s_port_bits),
        .s_timestamp  (s_timestamp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_axis_0     (m_axis_0),
        .m_axis_1     (m_axis_1),
        .m_axis_2     (m_axis_2),
        .m_axis_3     (m_axis_3),
        .m_capture_ok (m_capture_ok)
    );

    // Predictor copy of the configuration
    logic [BITS_W-1:0] cfg_mask;
    logic [TIME_W-1:0] cfg_gap;
    logic [TIME_W-1:0] cfg_timeout;
    logic [TIME_W-1:0] cfg_tpm;

    // Predictor copy of the capture state
    logic [TIME_W-1:0]               cap_start;
    logic [TIME_W-1:0]               last_poll_time;
    logic [BITS_W-1:0]               last_bits;
    int                              n_logged;
    logic [BITS_W-1:0]               logged_bits [MAX_CHANGES];
    logic [TIME_W-1:0]               logged_time [MAX_CHANGES];
    logic [NUM_AXES-1:0][AXIS_W-1:0] held_pos;
    bit                              cap_active;

    capture_result_t expected_captures [$];
    int              mismatches;
    int              live_items;
    int              burst_left;
    int              hold_seq;
    int              stall_cycles;

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void reset_model();
        cfg_mask       = RST_AXIS_MASK;
        cfg_gap        = RST_POLL_GAP_LIMIT;
        cfg_timeout    = RST_CAPTURE_TIMEOUT;
        cfg_tpm        = RST_TICKS_PER_MS;
        cap_start      = '0;
        last_poll_time = '0;
        last_bits      = '0;
        n_logged       = 0;
        held_pos       = '0;
        cap_active     = 1'b0;
        for (int k = 0; k < MAX_CHANGES; k++) begin
            logged_bits[k] = '0;
            logged_time[k] = '0;
        end
    endfunction

    // Elapsed time since the trigger, shifted and divided, saturating
    function automatic logic [AXIS_W-1:0] scaled_pos(logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] delta;
        logic [63:0]       q;
        delta = t - cap_start;
        if (cfg_tpm == '0)
            return AXIS_SAT;
        q = {32'd0, delta} << SCALE_SHIFT;
        q = q / {32'd0, cfg_tpm};
        return (q > 64'(AXIS_SAT)) ? AXIS_SAT : q[AXIS_W-1:0];
    endfunction

    function automatic void predict_capture(logic act, logic [BITS_W-1:0] bits,
                                            logic [TIME_W-1:0] now);
        logic [BITS_W-1:0] cur;
        logic [BITS_W-1:0] diff;
        logic [BITS_W-1:0] seen;
        logic [TIME_W-1:0] since_poll;
        logic [TIME_W-1:0] since_start;
        logic [AXIS_W-1:0] pos;
        bit                finished;
        capture_result_t   res;
        // Trigger restarts the capture unconditionally
        if (act == ACT_TRIGGER) begin
            cap_start      = now;
            last_poll_time = now;
            last_bits      = cfg_mask;
            n_logged       = 0;
            cap_active     = 1'b1;
            live_items++;
            return;
        end
        if (!cap_active)
            return;
        live_items++;

        // Log a change only when the poll gap is short enough
        cur        = bits & cfg_mask;
        diff       = last_bits ^ cur;
        since_poll = now - last_poll_time;
        if (diff != '0 && since_poll < cfg_gap && n_logged < MAX_CHANGES) begin
            logged_bits[n_logged] = diff;
            logged_time[n_logged] = now;
            n_logged++;
        end
        last_poll_time = now;
        last_bits      = cur;

        since_start = now - cap_start;
        finished = !(cur != '0 && n_logged < MAX_CHANGES && since_start < cfg_timeout);
        if (!finished)
            return;

        // Walk newest to oldest so the earliest change of an axis stands
        seen = '0;
        for (int k = n_logged - 1; k >= 0; k--) begin
            pos  = scaled_pos(logged_time[k]);
            seen = seen | logged_bits[k];
            for (int j = 0; j < NUM_AXES; j++)
                if (logged_bits[k][j])
                    held_pos[j] = pos;
        end
        cap_active = 1'b0;
        res.axes   = held_pos;
        res.ok     = (cur == '0 && seen == cfg_mask);
        expected_captures.push_back(res);
    endfunction

    // Track register writes and input transactions as they are accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_AXIS_MASK:       cfg_mask    = cfg_data[BITS_W-1:0];
                    REG_POLL_GAP_LIMIT:  cfg_gap     = cfg_data;
                    REG_CAPTURE_TIMEOUT: cfg_timeout = cfg_data;
                    REG_TICKS_PER_MS:    cfg_tpm     = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_capture(s_action, s_port_bits, s_timestamp);
        end
    end

    // Compare each result transaction with the oldest expected capture
    always @(posedge aclk) begin : result_check
        capture_result_t             want;
        logic [NUM_AXES-1:0][AXIS_W-1:0] got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_axis_3, m_axis_2, m_axis_1, m_axis_0};
            if (expected_captures.size() == 0) begin
                $error("result transaction with no capture expected");
                mismatches++;
            end else begin
                want = expected_captures.pop_front();
                for (int j = 0; j < NUM_AXES; j++) begin
                    if (got[j] !== want.axes[j]) begin
                        $error("axis_%0d expected %0d actual %0d", j, want.axes[j], got[j]);
                        mismatches++;
                    end
                end
                if (m_capture_ok !== want.ok) begin
                    $error("capture_ok expected %0d actual %0d", want.ok, m_capture_ok);
                    mismatches++;
                end
            end
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result sink: random stall modes, plus long hold-offs on request
    initial begin : result_sink
        int mode;
        int mode_left;
        int hold_left;
        int hold_seen;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    0: m_ready = 1'b1;
                    1: m_ready = 1'($urandom_range(0, 1));
                    default: m_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one input transaction, in bursts separated by random gaps
    task automatic send_item(logic act, logic [BITS_W-1:0] bits, logic [TIME_W-1:0] ts);
        int gap;
        if (burst_left == 0) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        s_valid     = 1'b1;
        s_action    = act;
        s_port_bits = bits;
        s_timestamp = ts;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [TIME_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Hold input, wait for every expected capture, then let the divider settle
    task automatic drain();
        s_valid = 1'b0;
        while (expected_captures.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_all(logic [BITS_W-1:0] mask, logic [TIME_W-1:0] gap,
                             logic [TIME_W-1:0] tmo, logic [TIME_W-1:0] tpm);
        logic [TIME_W-1:0] mask_word;
        mask_word = $urandom;
        mask_word[BITS_W-1:0] = mask;
        write_reg(REG_AXIS_MASK, mask_word);
        write_reg(REG_POLL_GAP_LIMIT, gap);
        write_reg(REG_CAPTURE_TIMEOUT, tmo);
        write_reg(REG_TICKS_PER_MS, tpm);
    endtask

    // Idle samples, a capture across the timestamp wrap
    task automatic test_idle_and_wrap();
        send_item(ACT_SAMPLE,  4'b1111, 32'h0000_0000);
        send_item(ACT_TRIGGER, 4'b0000, 32'hFFFF_FFF0);
        send_item(ACT_SAMPLE,  4'b1110, 32'hFFFF_FFFA);
        send_item(ACT_SAMPLE,  4'b1100, 32'h0000_0004);
        send_item(ACT_SAMPLE,  4'b0000, 32'h0000_000E);
        send_item(ACT_SAMPLE,  4'b1111, 32'h0000_0020);
    endtask

    // Retrigger, change-count limit, a change lost to a long poll gap
    task automatic test_restart_and_limit();
        send_item(ACT_TRIGGER, 4'b1111, 32'd1000);
        send_item(ACT_TRIGGER, 4'b0000, 32'd2000);
        send_item(ACT_SAMPLE,  4'b0111, 32'd2050);
        send_item(ACT_SAMPLE,  4'b0011, 32'd2060);
        send_item(ACT_SAMPLE,  4'b0001, 32'd2070);
        send_item(ACT_SAMPLE,  4'b1001, 32'd2080);
        send_item(ACT_TRIGGER, 4'b0000, 32'd5000);
        send_item(ACT_SAMPLE,  4'b0111, 32'd5200);
        send_item(ACT_SAMPLE,  4'b0000, 32'd5210);
    endtask

    // Register extremes and the mask changed under a running capture
    task automatic test_config_extremes();
        drain();
        write_reg(REG_CAPTURE_TIMEOUT, 32'd0);
        send_item(ACT_TRIGGER, 4'b0000, 32'd100);
        send_item(ACT_SAMPLE,  4'b1111, 32'd101);

        drain();
        write_reg(REG_CAPTURE_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(REG_TICKS_PER_MS, 32'd0);
        send_item(ACT_TRIGGER, 4'b0000, 32'd7);
        send_item(ACT_SAMPLE,  4'b0000, 32'd8);

        drain();
        write_reg(REG_TICKS_PER_MS, 32'd1);
        write_reg(REG_POLL_GAP_LIMIT, 32'hFFFF_FFFF);
        send_item(ACT_TRIGGER, 4'b0000, 32'd0);
        send_item(ACT_SAMPLE,  4'b0101, 32'h0010_0000);
        send_item(ACT_SAMPLE,  4'b0000, 32'h8000_0000);

        drain();
        write_reg(REG_POLL_GAP_LIMIT, 32'd0);
        send_item(ACT_TRIGGER, 4'b0000, 32'd50);
        send_item(ACT_SAMPLE,  4'b0000, 32'd50);

        drain();
        write_reg(REG_POLL_GAP_LIMIT, 32'd100);
        write_reg(REG_TICKS_PER_MS, 32'hFFFF_FFFF);
        send_item(ACT_TRIGGER, 4'b0000, 32'd9);
        drain();
        write_reg(REG_AXIS_MASK, 32'd3);
        send_item(ACT_SAMPLE,  4'b0000, 32'd14);

        drain();
        write_reg(REG_AXIS_MASK, 32'd0);
        send_item(ACT_TRIGGER, 4'b1111, 32'd20);
        send_item(ACT_SAMPLE,  4'b1111, 32'd21);
    endtask

    // Hold off the sink while short captures keep arriving
    task automatic test_backpressure();
        logic [TIME_W-1:0] t;
        drain();
        write_all(4'hF, 32'd100, 32'd3000, 32'd1000);
        hold_seq++;
        t = $urandom;
        repeat (20) begin
            send_item(ACT_TRIGGER, 4'b0000, t);
            t = t + $urandom_range(1, 99);
            send_item(ACT_SAMPLE, 4'b0000, t);
            t = t + $urandom_range(1, 500);
        end
        drain();
    endtask

    task automatic pick_settings(int phase);
        logic [BITS_W-1:0] m;
        logic [TIME_W-1:0] g;
        logic [TIME_W-1:0] to;
        logic [TIME_W-1:0] d;
        case (phase)
            0: begin
                m = 4'hF; g = 32'hFFFF_FFFF; to = 32'hFFFF_FFFF; d = 32'd1;
            end
            1: begin
                m = 4'($urandom_range(1, 15)); g = 32'd1; to = 32'd0; d = 32'hFFFF_FFFF;
            end
            2: begin
                m = 4'hF; g = $urandom_range(20, 300); to = $urandom_range(200, 3000);
                d = 32'hFFFF_FFFF;
            end
            default: begin
                m  = ($urandom_range(0, 9) < 7) ? 4'hF : 4'($urandom_range(0, 15));
                g  = $urandom_range(20, 400);
                to = $urandom_range(300, 8000);
                case ($urandom_range(0, 3))
                    0: d = $urandom_range(1, 50);
                    1: d = $urandom;
                    default: d = $urandom_range(100, 100000);
                endcase
            end
        endcase
        write_all(m, g, to, d);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom);
    endtask

    // One discharge sequence: every axis falls after a random number of polls
    task automatic run_capture();
        logic [TIME_W-1:0] t;
        logic [BITS_W-1:0] bits;
        int unsigned       fall [NUM_AXES];
        int unsigned       n_samples;
        int unsigned       step_hi;
        int unsigned       flip;
        t = $urandom;
        send_item(ACT_TRIGGER, 4'($urandom_range(0, 15)), t);
        if (cfg_gap == '0)
            step_hi = 0;
        else if (cfg_gap > 201)
            step_hi = 200;
        else
            step_hi = cfg_gap - 1;
        n_samples = 0;
        for (int j = 0; j < NUM_AXES; j++) begin
            fall[j] = $urandom_range(1, 12);
            if (fall[j] > n_samples)
                n_samples = fall[j];
        end
        for (int k = 1; k <= n_samples; k++) begin
            if (!cap_active)
                break;
            if ($urandom_range(0, 9) == 0)
                t = t + $urandom;
            else
                t = t + $urandom_range(0, step_hi);
            for (int j = 0; j < NUM_AXES; j++)
                bits[j] = (k < fall[j]);
            if ($urandom_range(0, 19) == 0) begin
                flip = $urandom_range(0, NUM_AXES - 1);
                bits[flip] = ~bits[flip];
            end
            if ($urandom_range(0, 29) == 0)
                send_item(ACT_TRIGGER, bits, t);
            else
                send_item(ACT_SAMPLE, bits, t);
        end
        // Occasionally poll once more after the capture has closed
        if ($urandom_range(0, 9) == 0)
            send_item(ACT_SAMPLE, 4'($urandom_range(0, 15)), t + 1);
    endtask

    task automatic test_random_captures();
        int phase;
        int goal;
        goal  = live_items + RANDOM_ITEMS;
        phase = 0;
        while (live_items < goal) begin
            drain();
            pick_settings(phase);
            phase++;
            repeat (PHASE_CAPTURES) begin
                if ($urandom_range(0, 99) < 15)
                    send_noise();
                else
                    run_capture();
            end
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_AXIS_MASK;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_action     = ACT_TRIGGER;
        s_port_bits  = '0;
        s_timestamp  = '0;
        mismatches   = 0;
        live_items   = 0;
        burst_left   = 0;
        hold_seq     = 0;
        stall_cycles = 0;
        reset_model();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_idle_and_wrap();
        test_restart_and_limit();
        test_config_extremes();
        test_backpressure();
        test_random_captures();
        drain();

        if (mismatches == 0 && expected_captures.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
